// File: hdl/assert_macros.svh
// assertion macros used by the checker file mcpw_checker.sv
// clocked on clk, disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/mcpw_pkg.sv
// shared types, constants and character decode functions
// used by every module of the motor command parser with watchdog
package mcpw_pkg;

    localparam int LINE_LENGTH = 6;
    localparam int CNT_W       = 3;
    localparam int IDLE_W      = 17;
    localparam int TIMEOUT_W   = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [IDLE_W-1:0]    IDLE_MAX      = 17'h0FFFF;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [3:0] HEX_ALPHA_OFS = 4'd9;

    localparam int PIN_LEFT_DIR    = 0;
    localparam int PIN_LEFT_BRAKE  = 1;
    localparam int PIN_RIGHT_DIR   = 2;
    localparam int PIN_RIGHT_BRAKE = 3;

    typedef enum logic [1:0] {
        DIR_BRAKE = 2'd0,
        DIR_FWD   = 2'd1,
        DIR_REV   = 2'd2,
        DIR_BAD   = 2'd3
    } dir_code_t;

    typedef enum logic [1:0] {
        ST_NONE      = 2'd0,
        ST_APPLIED   = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_TIMEOUT   = 2'd3
    } status_t;

    typedef logic [LINE_LENGTH-1:0][7:0] line_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] left_pwm;
        logic [7:0] right_pwm;
        logic [3:0] pins;
    } decode_t;

    typedef struct packed {
        logic [7:0] left_pwm;
        logic [7:0] right_pwm;
        logic [3:0] pins;
        status_t    status;
    } result_t;

    function automatic dir_code_t letter_code(input logic [7:0] ch);
        dir_code_t code;
        case (ch)
            8'h46, 8'h66: code = DIR_FWD;
            8'h42, 8'h62: code = DIR_BRAKE;
            8'h52, 8'h72: code = DIR_REV;
            default:      code = DIR_BAD;
        endcase
        return code;
    endfunction

    // bit 4 flags a bad digit
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        logic [4:0] d;
        case (ch) inside
            [8'h30:8'h39]: d = {1'b0, ch[3:0]};
            [8'h41:8'h46],
            [8'h61:8'h66]: d = {1'b0, ch[3:0] + HEX_ALPHA_OFS};
            default:       d = 5'h10;
        endcase
        return d;
    endfunction

endpackage

// File: hdl/mcpw_line_decode.sv
// decodes a full six-character line into two wheel commands
// depends on mcpw_pkg
module mcpw_line_decode (
    input  mcpw_pkg::line_t   line,
    output mcpw_pkg::decode_t dec
);
    import mcpw_pkg::*;

    dir_code_t  ld;
    dir_code_t  rd;
    logic [4:0] lh;
    logic [4:0] ll;
    logic [4:0] rh;
    logic [4:0] rl;

    always_comb
    begin
        ld = letter_code(line[0]);
        rd = letter_code(line[3]);
        lh = hex_digit(line[1]);
        ll = hex_digit(line[2]);
        rh = hex_digit(line[4]);
        rl = hex_digit(line[5]);

        dec.ok = (ld != DIR_BAD) && (rd != DIR_BAD)
            && !lh[4] && !ll[4] && !rh[4] && !rl[4];
        dec.left_pwm  = {lh[3:0], ll[3:0]};
        dec.right_pwm = {rh[3:0], rl[3:0]};
        dec.pins[PIN_LEFT_DIR]    = (ld != DIR_REV);
        dec.pins[PIN_LEFT_BRAKE]  = (ld == DIR_BRAKE);
        dec.pins[PIN_RIGHT_DIR]   = (rd == DIR_REV);
        dec.pins[PIN_RIGHT_BRAKE] = (rd == DIR_BRAKE);
    end

endmodule

// File: hdl/mcpw_engine.sv
// line buffer, held motor outputs and watchdog count, one item per step
// depends on mcpw_pkg and mcpw_line_decode
module mcpw_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  logic                               mode,
    input  logic [7:0]                         rx_byte,
    input  logic [mcpw_pkg::TIMEOUT_W-1:0]     timeout_ticks,
    output mcpw_pkg::result_t                  result
);
    import mcpw_pkg::*;

    line_t             line_reg;
    logic              buf_we;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [IDLE_W-1:0] idle_reg;
    logic [IDLE_W-1:0] idle_next;
    logic [IDLE_W-1:0] idle_inc;
    logic [7:0]        lpwm_reg;
    logic [7:0]        lpwm_next;
    logic [7:0]        rpwm_reg;
    logic [7:0]        rpwm_next;
    logic [3:0]        pins_reg;
    logic [3:0]        pins_next;
    status_t           status;
    decode_t           dec;

    mcpw_line_decode u_decode (
        .line (line_reg),
        .dec  (dec)
    );

    always_comb
    begin
        buf_we     = 1'b0;
        count_next = count_reg;
        idle_next  = idle_reg;
        lpwm_next  = lpwm_reg;
        rpwm_next  = rpwm_reg;
        pins_next  = pins_reg;
        status     = ST_NONE;
        idle_inc   = (idle_reg <= IDLE_MAX) ? idle_reg + 1'b1 : idle_reg;

        if (step)
        begin
            if (!mode)
            begin
                if (rx_byte != CH_NEWLINE)
                begin
                    if (count_reg < CNT_W'(LINE_LENGTH))
                    begin
                        buf_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                begin
                    count_next = '0;
                    if (count_reg == CNT_W'(LINE_LENGTH) && dec.ok)
                    begin
                        lpwm_next = dec.left_pwm;
                        rpwm_next = dec.right_pwm;
                        pins_next = dec.pins;
                        idle_next = '0;
                        status    = ST_APPLIED;
                    end
                    else
                    begin
                        status = ST_MALFORMED;
                    end
                end
            end
            else
            begin
                idle_next = idle_inc;
                if (idle_inc > {1'b0, timeout_ticks})
                begin
                    lpwm_next = '0;
                    rpwm_next = '0;
                    idle_next = '0;
                    status    = ST_TIMEOUT;
                end
            end
        end
    end

    always_comb
    begin
        result.left_pwm  = lpwm_next;
        result.right_pwm = rpwm_next;
        result.pins      = pins_next;
        result.status    = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idle_reg  <= '0;
            lpwm_reg  <= '0;
            rpwm_reg  <= '0;
            pins_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idle_reg  <= idle_next;
            lpwm_reg  <= lpwm_next;
            rpwm_reg  <= rpwm_next;
            pins_reg  <= pins_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            line_reg[count_reg] <= rx_byte;
        end
    end

endmodule

// File: hdl/motor_command_parser_watchdog.sv
// top level: motor command parser with watchdog
// depends on mcpw_pkg and mcpw_engine
//
//   channel   signals                        payload
//   s_*       s_tvalid s_tready s_tdata s_tuser   received byte or tick
//   m_*       m_tvalid m_tready m_tdata m_tuser   held motor outputs and status
//   cfg_*     cfg_wen cfg_wdata                    timeout_ticks
//
// one item per cycle while results are taken; an item is registered on input,
// processed once the result register is free, and its result is then registered
// the result register frees as the item moves on, so input keeps flowing
// while a result waits, until both the input and result registers are full
// reset clears all control state; timeout_ticks resets to 5000
module motor_command_parser_watchdog (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // rx_byte
    input  logic                               s_tuser,   // mode
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // left_pwm, left_dir, left_brake, right_pwm, right_dir, right_brake, zero pad
    output logic [23:0]                        m_tdata,
    output logic [1:0]                         m_tuser,   // status
    input  logic                               cfg_wen,
    input  logic [mcpw_pkg::TIMEOUT_W-1:0]     cfg_wdata
);
    import mcpw_pkg::*;

    logic                 in_vld_reg;
    logic                 in_mode_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_vld_reg;
    result_t              out_reg;
    result_t              result;
    logic                 advance;
    logic [TIMEOUT_W-1:0] timeout_reg;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    mcpw_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .mode          (in_mode_reg),
        .rx_byte       (in_byte_reg),
        .timeout_ticks (timeout_reg),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_wen)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0000,
                       out_reg.pins[PIN_RIGHT_BRAKE], out_reg.pins[PIN_RIGHT_DIR],
                       out_reg.right_pwm,
                       out_reg.pins[PIN_LEFT_BRAKE], out_reg.pins[PIN_LEFT_DIR],
                       out_reg.left_pwm};
    assign m_tuser  = out_reg.status;

endmodule

// File: hdl/mcpw_checker.sv
// port-level checks for the motor command parser, bound to the top level
// depends on mcpw_pkg and assert_macros.svh
`include "assert_macros.svh"

module mcpw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import mcpw_pkg::*;

    logic [7:0] left_pwm;
    logic [7:0] right_pwm;
    logic       left_dir;
    logic       left_brake;
    logic       right_dir;
    logic       right_brake;

    assign left_pwm    = m_tdata[7:0];
    assign left_dir    = m_tdata[8];
    assign left_brake  = m_tdata[9];
    assign right_pwm   = m_tdata[17:10];
    assign right_dir   = m_tdata[18];
    assign right_brake = m_tdata[19];

    // a timeout stop always shows both wheels at zero
    `ASSERT_IMPLIES(a_timeout_zero, m_tvalid && m_tuser == ST_TIMEOUT, ~|{left_pwm, right_pwm})

    // brake never comes with a reverse direction pin
    `ASSERT_IMPLIES(a_left_brake, m_tvalid && left_brake, left_dir)
    `ASSERT_IMPLIES(a_right_brake, m_tvalid && right_brake, !right_dir)

    // input stalls only behind a waiting result
    `ASSERT_IMPLIES(a_stall_cause, !s_tready, m_tvalid)

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind motor_command_parser_watchdog mcpw_checker u_mcpw_checker (.*);

// File: tb/motor_command_parser_watchdog_tb.sv
// self-checking testbench for motor_command_parser_watchdog
// predicts held motor outputs and status for every byte or tick item
// needs mcpw_pkg and the rtl of the block
`timescale 1ns / 1ps

module motor_command_parser_watchdog_tb;

    import mcpw_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
    typedef enum {LINE_GOOD, LINE_CORRUPT, LINE_OVERLONG, LINE_SHORT} line_kind_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] ch;
    } serial_item_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_wen   = 1'b0;
    logic [TIMEOUT_W-1:0] cfg_wdata = '0;

    serial_item_t serial_q[$];
    result_t      motor_out_q[$];
    serial_item_t drive_item;
    idle_mode_t   idle_mode = IDLE_NONE;
    int unsigned  queued_cnt = 0;
    int unsigned  mismatch_cnt = 0;
    bit           hold_req = 1'b0;
    int           hold_left = 0;
    int           quiet_cycles = 0;

    // predicted block state
    logic [7:0]           line_chars [0:LINE_LENGTH-1];
    int                   line_len;
    logic [IDLE_W-1:0]    idle_cnt;
    logic [7:0]           pwm_l;
    logic [7:0]           pwm_r;
    logic [3:0]           pin_state;
    logic [TIMEOUT_W-1:0] timeout_val;

    motor_command_parser_watchdog u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic dir_code_t dir_of_char(input logic [7:0] ch);
        case (ch)
            "F", "f": return DIR_FWD;
            "B", "b": return DIR_BRAKE;
            "R", "r": return DIR_REV;
            default:  return DIR_BAD;
        endcase
    endfunction

    function automatic bit nibble_of(input logic [7:0] ch, output logic [3:0] n);
        logic [7:0] d;
        n = 4'd0;
        if (ch >= "0" && ch <= "9")
            d = ch - 8'h30;
        else if (ch >= "A" && ch <= "F")
            d = ch - 8'h41 + 8'd10;
        else if (ch >= "a" && ch <= "f")
            d = ch - 8'h61 + 8'd10;
        else
            return 1'b0;
        n = d[3:0];
        return 1'b1;
    endfunction

    function automatic bit speed_of(input logic [7:0] hi, input logic [7:0] lo,
                                    output logic [7:0] v);
        logic [3:0] a;
        logic [3:0] b;
        bit         ok;
        ok = nibble_of(hi, a);
        ok = nibble_of(lo, b) && ok;
        v = {a, b};
        return ok;
    endfunction

    function automatic status_t apply_line();
        dir_code_t  ld;
        dir_code_t  rd;
        logic [7:0] ls;
        logic [7:0] rs;
        bit         lok;
        bit         rok;
        ld  = dir_of_char(line_chars[0]);
        rd  = dir_of_char(line_chars[3]);
        lok = speed_of(line_chars[1], line_chars[2], ls);
        rok = speed_of(line_chars[4], line_chars[5], rs);
        if (ld == DIR_BAD || rd == DIR_BAD || !lok || !rok)
            return ST_MALFORMED;
        pwm_l = ls;
        pwm_r = rs;
        pin_state = '0;
        pin_state[PIN_LEFT_DIR]    = (ld != DIR_REV);
        pin_state[PIN_LEFT_BRAKE]  = (ld == DIR_BRAKE);
        pin_state[PIN_RIGHT_DIR]   = (rd == DIR_REV);
        pin_state[PIN_RIGHT_BRAKE] = (rd == DIR_BRAKE);
        idle_cnt = '0;
        return ST_APPLIED;
    endfunction

    function automatic result_t motor_outputs_after(input logic mode, input logic [7:0] ch);
        result_t r;
        status_t st;
        st = ST_NONE;
        if (!mode)
        begin
            if (ch != CH_NEWLINE)
            begin
                if (line_len < LINE_LENGTH)
                begin
                    line_chars[line_len] = ch;
                    line_len++;
                end
            end
            else
            begin
                st = (line_len == LINE_LENGTH) ? apply_line() : ST_MALFORMED;
                line_len = 0;
            end
        end
        else
        begin
            if (idle_cnt <= IDLE_MAX)
                idle_cnt = idle_cnt + 1'b1;
            if (idle_cnt > {1'b0, timeout_val})
            begin
                pwm_l = '0;
                pwm_r = '0;
                idle_cnt = '0;
                st = ST_TIMEOUT;
            end
        end
        r.left_pwm  = pwm_l;
        r.right_pwm = pwm_r;
        r.pins      = pin_state;
        r.status    = st;
        return r;
    endfunction

    function automatic bit sender_pauses();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(0, 99) < 45;
            IDLE_BOTH: return $urandom_range(0, 99) < 16;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(0, 99) < 45;
            IDLE_BOTH: return $urandom_range(0, 99) < 16;
            default:   return 1'b0;
        endcase
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                motor_out_q.push_back(motor_outputs_after(s_tuser, s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (serial_q.size() != 0 && !sender_pauses())
                begin
                    drive_item = serial_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= drive_item.mode;
                    s_tdata  <= drive_item.ch;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (motor_out_q.size() == 0)
                begin
                    $error("result with nothing pending: data %h status %0d", m_tdata, m_tuser);
                    mismatch_cnt++;
                end
                else
                begin
                    result_t want;
                    want = motor_out_q.pop_front();
                    check_field("left_pwm", want.left_pwm, m_tdata[7:0]);
                    check_field("left_dir", want.pins[PIN_LEFT_DIR], m_tdata[8]);
                    check_field("left_brake", want.pins[PIN_LEFT_BRAKE], m_tdata[9]);
                    check_field("right_pwm", want.right_pwm, m_tdata[17:10]);
                    check_field("right_dir", want.pins[PIN_RIGHT_DIR], m_tdata[18]);
                    check_field("right_brake", want.pins[PIN_RIGHT_BRAKE], m_tdata[19]);
                    check_field("status", want.status, m_tuser);
                end
            end
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !receiver_stalls();
        end
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic push_item(input logic mode, input logic [7:0] ch);
        serial_item_t it;
        it.mode = mode;
        it.ch   = ch;
        serial_q.push_back(it);
        queued_cnt++;
    endtask

    task automatic push_text_line(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_item(1'b0, s[i]);
        push_item(1'b0, CH_NEWLINE);
    endtask

    task automatic push_ticks(input int n);
        repeat (n)
            push_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 5))
            0:       return "F";
            1:       return "f";
            2:       return "B";
            3:       return "b";
            4:       return "R";
            default: return "r";
        endcase
    endfunction

    function automatic logic [7:0] pick_hex();
        int unsigned v;
        v = $urandom_range(0, 21);
        if (v < 10)
            return 8'h30 + 8'(v);
        else if (v < 16)
            return 8'h61 + 8'(v - 10);
        else
            return 8'h41 + 8'(v - 16);
    endfunction

    function automatic logic [7:0] pick_junk();
        logic [7:0] ch;
        ch = 8'($urandom_range(0, 255));
        if (ch == CH_NEWLINE)
            ch = 8'hFF;
        return ch;
    endfunction

    task automatic push_command(input line_kind_t kind);
        logic [7:0] cmd_chars [0:5];
        int         n;
        int         i;
        cmd_chars[0] = pick_letter();
        cmd_chars[1] = pick_hex();
        cmd_chars[2] = pick_hex();
        cmd_chars[3] = pick_letter();
        cmd_chars[4] = pick_hex();
        cmd_chars[5] = pick_hex();
        n = 6;
        if (kind == LINE_CORRUPT)
            cmd_chars[$urandom_range(0, 5)] = pick_junk();
        if (kind == LINE_SHORT)
            n = $urandom_range(0, 5);
        for (i = 0; i < n; i++)
            push_item(1'b0, cmd_chars[i]);
        if (kind == LINE_OVERLONG)
            repeat ($urandom_range(1, 5))
                push_item(1'b0, pick_junk());
        push_item(1'b0, CH_NEWLINE);
    endtask

    task automatic push_random_group();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            push_command(LINE_GOOD);
        else if (pick < 65)
            push_command(LINE_CORRUPT);
        else if (pick < 71)
            push_command(LINE_OVERLONG);
        else if (pick < 77)
            push_command(LINE_SHORT);
        else if (pick < 95)
            push_ticks($urandom_range(1, 12));
        else
            push_item(1'b0, pick_junk());
    endtask

    task automatic wait_drained();
        while (serial_q.size() != 0 || s_tvalid || motor_out_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] v);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        timeout_val = v;
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned tmo_list [0:6];
        int unsigned stop_at;
        int          p;
        tmo_list = '{3, 1, 17, 65535, 2, 250, 8};

        for (int i = 0; i < LINE_LENGTH; i++)
            line_chars[i] = '0;
        line_len    = 0;
        idle_cnt    = '0;
        pwm_l       = '0;
        pwm_r       = '0;
        pin_state   = '0;
        timeout_val = TIMEOUT_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: letters in both cases, speed extremes, bad lines
        push_text_line("fFFbA9");
        push_text_line("R00r5e");
        push_text_line("");
        push_text_line("X12F34");
        push_text_line("F/9F:g");
        push_text_line("r@`RG0");
        push_text_line("B12R34zz");
        push_text_line("F1");
        push_item(1'b0, 8'hFF);
        push_item(1'b0, 8'h00);
        push_item(1'b0, CH_NEWLINE);
        push_item(1'b1, 8'hFF);
        wait_drained();

        // smallest timeout: second tick stops, pins kept
        write_timeout(16'd1);
        push_text_line("B10R20");
        push_ticks(3);
        wait_drained();

        for (p = 0; p < 7; p++)
        begin
            write_timeout(tmo_list[p][TIMEOUT_W-1:0]);
            idle_mode = idle_mode_t'(p % 4);
            stop_at = queued_cnt + 85;
            while (queued_cnt < stop_at)
                push_random_group();
            if (p == 4)
                hold_req = 1'b1;
            wait_drained();
        end

        // largest timeout, count stays well under it
        idle_mode = IDLE_NONE;
        write_timeout(16'hFFFF);
        push_command(LINE_GOOD);
        push_ticks(30);
        wait_drained();

        // timeout lowered under the running count
        push_command(LINE_GOOD);
        push_ticks(20);
        wait_drained();
        write_timeout(16'd4);
        push_ticks(2);
        wait_drained();

        repeat (5) @(posedge clk);
        if (mismatch_cnt == 0 && motor_out_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
